@@ rtl/srti_pkg.sv @@
// shared constants for the sorted range table insert unit
// depends on nothing; used by the top level and the checker
`default_nettype none

package srti_pkg;

  localparam int unsigned DepthDefault   = 256;
  localparam int unsigned PayloadDefault = 16;

  localparam int unsigned IdxBits  = 32;
  localparam int unsigned PayBits  = 16;
  localparam int unsigned RidxBits = 8;
  localparam int unsigned StatBits = 2;

  localparam logic [StatBits-1:0] StatOk       = 2'd0;
  localparam logic [StatBits-1:0] StatFull     = 2'd1;
  localparam logic [StatBits-1:0] StatBadRange = 2'd2;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRead   = 1'b1;

endpackage

`default_nettype wire

@@ rtl/srti_mem.sv @@
// entry memory of the range table: one write and one read port, read data registered
// depends on nothing
`default_nettype none

module srti_mem #(
  parameter int unsigned AW = 8,
  parameter int unsigned EW = 80
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [EW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [EW-1:0] rdata_o
);

  logic [EW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sorted_range_table_insert_unit.sv @@
// top level of the sorted range table insert unit: controller and entry memory
// depends on srti_pkg and srti_mem
//
// usage:
// - input channel (in_valid_i/in_ready_o) takes one word: mode, new range and
//   payload, read index. output channel (out_valid_o/out_ready_i) returns one
//   word per input word: status, read entry, entry count after the word
// - the table of sorted, disjoint ranges sits in one single-port-read memory;
//   every step reads at most one entry and writes at most one entry
// - read word: the memory read is issued on accept, S_READ takes the data, S_DONE loads the result
// - insert word: a linear scan to find the first overlapped entry and the
//   first entry reaching past the new range (one entry per cycle), then a
//   move of that entry and the entries behind it (one per cycle, top down
//   when the table grows, bottom up otherwise), then up to two entry writes;
//   scan and move read the entries one at a time through the one memory
//   port, which sets the worst case
// - a bad range goes straight to S_DONE; a full table passes S_DEC, S_FLEFT
//   and S_FJ after the scan (only S_DEC for a split) before S_DONE
// - one word is worked on at a time; the next word is taken as soon as the
//   previous one is finished, even when its result still waits in the output
//   register
// - reset clears the entry count; memory contents stay unknown and are never
//   read at or above the count
// - a stalled receiver holds the result; a finished word then waits for it
`default_nettype none

module sorted_range_table_insert_unit #(
  parameter int unsigned DEPTH        = srti_pkg::DepthDefault,
  parameter int unsigned PAYLOAD_BITS = srti_pkg::PayloadDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input words
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             mode_i,
  input  wire logic [srti_pkg::IdxBits-1:0]     new_first_i,
  input  wire logic [srti_pkg::IdxBits-1:0]     new_last_i,
  input  wire logic [srti_pkg::PayBits-1:0]     new_payload_i,
  input  wire logic [srti_pkg::RidxBits-1:0]    read_index_i,
  // result words
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [srti_pkg::StatBits-1:0]         status_o,
  output logic                                  entry_valid_o,
  output logic [srti_pkg::IdxBits-1:0]          entry_first_o,
  output logic [srti_pkg::IdxBits-1:0]          entry_last_o,
  output logic [srti_pkg::PayBits-1:0]          entry_payload_o,
  output logic [$clog2(DEPTH+1)-1:0]            entry_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned SW = (PAYLOAD_BITS < srti_pkg::PayBits) ? PAYLOAD_BITS
                                                                  : srti_pkg::PayBits;
  localparam int unsigned EW = 2 * srti_pkg::IdxBits + SW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_MOVE  = 4'd3;
  localparam logic [3:0] S_NEW   = 4'd4;
  localparam logic [3:0] S_LEFT  = 4'd5;
  localparam logic [3:0] S_FLEFT = 4'd6;
  localparam logic [3:0] S_FJ    = 4'd7;
  localparam logic [3:0] S_READ  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;

  // item being worked on
  logic [31:0]   f_q, f_d, l_q, l_d;
  logic [SW-1:0] p_q, p_d;

  // scan and move bookkeeping
  logic [CW-1:0] ptr_q, ptr_d, tag_q, tag_d, rem_q, rem_d;
  logic          rv_q, rv_d;
  logic          found_q, found_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [EW-1:0] ei_q, ei_d, ej_q, ej_d;
  logic          lt_q, lt_d, up_q, up_d;
  logic [CW:0]   ncount_q, ncount_d;

  // staged result
  logic [1:0]    st_q, st_d;
  logic          rvld_q, rvld_d;
  logic [EW-1:0] rent_q, rent_d;

  // output register
  logic          ov_q, ov_d;
  logic [1:0]    ost_q, ost_d;
  logic          oev_q, oev_d;
  logic [EW-1:0] oent_q, oent_d;
  logic [CW-1:0] ocnt_q, ocnt_d;

  // memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  srti_mem #(.AW(AW), .EW(EW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic [31:0] rd_first, rd_last, lp1, ei_first, ej_first;
  logic [CW:0] nc_calc;
  logic        lt_calc;
  logic        in_fire;

  assign rd_first = mem_rdata[EW-1 -: 32];
  assign rd_last  = mem_rdata[SW+31 -: 32];
  assign ei_first = ei_q[EW-1 -: 32];
  assign ej_first = ej_q[EW-1 -: 32];
  assign lp1      = l_q + 32'd1;
  assign lt_calc  = (i_q < count_q) && (ei_first < f_q);
  assign nc_calc  = (CW+1)'(i_q) + (CW+1)'(lt_calc) + (CW+1)'(1)
                  + (CW+1)'(count_q) - (CW+1)'(j_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    f_d      = f_q;
    l_d      = l_q;
    p_d      = p_q;
    ptr_d    = ptr_q;
    tag_d    = tag_q;
    rem_d    = rem_q;
    rv_d     = 1'b0;
    found_d  = found_q;
    i_d      = i_q;
    j_d      = j_q;
    ei_d     = ei_q;
    ej_d     = ej_q;
    lt_d     = lt_q;
    up_d     = up_q;
    ncount_d = ncount_q;
    st_d     = st_q;
    rvld_d   = rvld_q;
    rent_d   = rent_q;
    ov_d     = ov_q && !out_ready_i;
    ost_d    = ost_q;
    oev_d    = oev_q;
    oent_d   = oent_q;
    ocnt_d   = ocnt_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          f_d    = new_first_i;
          l_d    = new_last_i;
          p_d    = new_payload_i[SW-1:0];
          st_d   = srti_pkg::StatOk;
          rvld_d = 1'b0;
          rent_d = '0;
          if (mode_i == srti_pkg::ModeRead) begin
            if (32'(read_index_i) < 32'(count_q)) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(read_index_i);
              state_d   = S_READ;
            end else begin
              state_d = S_DONE;
            end
          end else if (new_last_i < new_first_i) begin
            st_d    = srti_pkg::StatBadRange;
            state_d = S_DONE;
          end else begin
            ptr_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      S_READ: begin
        rvld_d  = 1'b1;
        rent_d  = mem_rdata;
        state_d = S_DONE;
      end

      // find first entry with last >= f, then first entry with last > l
      S_SCAN: begin
        if (ptr_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[AW-1:0];
          rv_d      = 1'b1;
          tag_d     = ptr_q;
          ptr_d     = ptr_q + CW'(1);
        end
        if (rv_q) begin
          if (!found_q && rd_last >= f_q) begin
            found_d = 1'b1;
            i_d     = tag_q;
            ei_d    = mem_rdata;
          end
          if ((found_q || rd_last >= f_q) && rd_last > l_q) begin
            j_d     = tag_q;
            ej_d    = mem_rdata;
            rv_d    = 1'b0;
            state_d = S_DEC;
          end
        end else if (ptr_q == count_q) begin
          i_d     = found_q ? i_q : count_q;
          j_d     = count_q;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        lt_d     = lt_calc;
        ncount_d = nc_calc;
        if (nc_calc > (CW+1)'(DEPTH)) begin
          st_d = srti_pkg::StatFull;
          // a strict split leaves the table as it is; other paths keep trims
          if (lt_calc && (j_q == i_q)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_FLEFT;
          end
        end else if (j_q < count_q) begin
          up_d    = nc_calc > (CW+1)'(count_q);
          ptr_d   = (nc_calc > (CW+1)'(count_q)) ? count_q - CW'(1) : j_q;
          rem_d   = count_q - j_q;
          state_d = S_MOVE;
        end else begin
          state_d = S_NEW;
        end
      end

      // shift entries j..count-1 to their new place, first one trimmed
      S_MOVE: begin
        if (rem_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[AW-1:0];
          rv_d      = 1'b1;
          tag_d     = ptr_q;
          ptr_d     = up_q ? ptr_q - CW'(1) : ptr_q + CW'(1);
          rem_d     = rem_q - CW'(1);
        end
        if (rv_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'((CW+1)'(tag_q) + ncount_q - (CW+1)'(count_q));
          mem_wdata = mem_rdata;
          if (tag_q == j_q && rd_first < lp1) begin
            mem_wdata[EW-1 -: 32] = lp1;
          end
        end
        if (!rv_q && rem_q == '0) begin
          state_d = S_NEW;
        end
      end

      S_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_q + CW'(lt_q));
        mem_wdata = {f_q, l_q, p_q};
        state_d   = lt_q ? S_LEFT : S_DONE;
        if (!lt_q) begin
          count_d = ncount_q[CW-1:0];
        end
      end

      S_LEFT: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[AW-1:0];
        mem_wdata = ei_q;
        mem_wdata[SW+31 -: 32] = f_q - 32'd1;
        count_d   = ncount_q[CW-1:0];
        state_d   = S_DONE;
      end

      // table full after trimming: trims of the overlapped entries remain
      S_FLEFT: begin
        if (lt_q) begin
          mem_we    = 1'b1;
          mem_waddr = i_q[AW-1:0];
          mem_wdata = ei_q;
          mem_wdata[SW+31 -: 32] = f_q - 32'd1;
        end
        state_d = S_FJ;
      end

      S_FJ: begin
        if (j_q < count_q && ej_first < lp1) begin
          mem_we    = 1'b1;
          mem_waddr = j_q[AW-1:0];
          mem_wdata = ej_q;
          mem_wdata[EW-1 -: 32] = lp1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ost_d   = st_q;
          oev_d   = rvld_q;
          oent_d  = rent_q;
          ocnt_d  = count_q;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      found_q <= found_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q      <= f_d;
    l_q      <= l_d;
    p_q      <= p_d;
    ptr_q    <= ptr_d;
    tag_q    <= tag_d;
    rem_q    <= rem_d;
    i_q      <= i_d;
    j_q      <= j_d;
    ei_q     <= ei_d;
    ej_q     <= ej_d;
    lt_q     <= lt_d;
    up_q     <= up_d;
    ncount_q <= ncount_d;
    st_q     <= st_d;
    rvld_q   <= rvld_d;
    rent_q   <= rent_d;
    ost_q    <= ost_d;
    oev_q    <= oev_d;
    oent_q   <= oent_d;
    ocnt_q   <= ocnt_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign entry_valid_o   = oev_q;
  assign entry_first_o   = oent_q[EW-1 -: 32];
  assign entry_last_o    = oent_q[SW+31 -: 32];
  assign entry_payload_o = srti_pkg::PayBits'(oent_q[SW-1:0]);
  assign entry_count_o   = ocnt_q;

endmodule

`default_nettype wire

@@ rtl/srti_checker.sv @@
// port-level checks for the sorted range table insert unit, bound to the top level
// depends on srti_pkg and sorted_range_table_insert_unit
`default_nettype none

module srti_checker #(
  parameter int unsigned DEPTH = srti_pkg::DepthDefault
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [srti_pkg::StatBits-1:0] status_o,
  input wire logic                          entry_valid_o,
  input wire logic [$clog2(DEPTH+1)-1:0]    entry_count_o
);

  // status and entry count of the result word hold while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(entry_count_o))
    else $error("result word changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == srti_pkg::StatOk || status_o == srti_pkg::StatFull
      || status_o == srti_pkg::StatBadRange)
    else $error("unknown status code");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> status_o == srti_pkg::StatOk
      && entry_count_o != '0)
    else $error("read word with error status or empty table");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(entry_count_o) <= 32'(DEPTH))
    else $error("entry count above capacity");

  // a full status comes only with an entry count of at least DEPTH-1
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == srti_pkg::StatFull |-> 32'(entry_count_o) + 32'd2 > 32'(DEPTH))
    else $error("table full reported with free room");

endmodule

bind sorted_range_table_insert_unit srti_checker #(.DEPTH(DEPTH)) u_srti_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .entry_valid_o (entry_valid_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire
